[rtl/core/fcull_pkg.sv]
// shared types and constants for the six-plane frustum cull test
// no dependencies

package fcull_pkg;

    localparam int NUM_PLANES_DEF = 6;
    localparam int PLANE_SLOTS    = 6;
    localparam int CFG_IDX_W      = 3;
    localparam int PLANE_W        = 64;
    localparam int COEF_W         = 16;
    localparam int COORD_W        = 16;
    localparam int SIZE_W         = 15;
    localparam int PROD_W         = 2 * COEF_W;
    localparam int EXT_W          = COEF_W + SIZE_W;
    localparam int D_SHIFT        = 14;
    localparam int DR_W           = COEF_W + 1;
    localparam int OFF_W          = DR_W + D_SHIFT;
    localparam int SUM_W          = PROD_W + 1;
    localparam int DIST_W         = SUM_W + 3;

    typedef enum logic [1:0] {
        OP_POINT  = 2'd0,
        OP_SPHERE = 2'd1,
        OP_BOX    = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic [SIZE_W-1:0]         half_x;
        logic [SIZE_W-1:0]         half_y;
        logic [SIZE_W-1:0]         half_z;
        logic [SIZE_W-1:0]         radius;
    } t_item;

endpackage

[rtl/core/fcull_plane_regs.sv]
// plane coefficient registers written through the configuration port
// depends on fcull_pkg

module fcull_plane_regs
    import fcull_pkg::*;
#(
    parameter int NUM_PLANES = NUM_PLANES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PLANE_W-1:0]   i_cfg_data,
    output logic [PLANE_W-1:0]   o_planes [NUM_PLANES]
);

    logic [PLANE_W-1:0] r_planes [NUM_PLANES];

    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_planes[g] <= '0;
            end else if (i_cfg_we && (i_cfg_idx == CFG_IDX_W'(g))) begin
                r_planes[g] <= i_cfg_data;
            end
        end
        assign o_planes[g] = r_planes[g];
    end

endmodule

[rtl/core/fcull_plane_unit.sv]
// three-stage distance pipeline for one clip plane: products, partial sums, sign test
// depends on fcull_pkg

module fcull_plane_unit
    import fcull_pkg::*;
(
    input  logic               i_clk,
    input  logic [PLANE_W-1:0] i_plane,
    input  t_item              i_item,
    output logic               o_pass
);

    logic signed [COEF_W-1:0] w_a, w_b, w_c, w_d;
    logic [COEF_W-1:0]        w_abs_a, w_abs_b, w_abs_c;
    logic signed [DR_W-1:0]   w_dr;
    logic                     w_box;
    logic signed [DIST_W-1:0] w_dist;

    logic signed [PROD_W-1:0] r_ax, r_by, r_cz;
    logic [EXT_W-1:0]         r_ex, r_ey, r_ez;
    logic signed [OFF_W-1:0]  r_off;
    logic signed [SUM_W-1:0]  r_s1, r_s2;
    logic [SUM_W-1:0]         r_s3;
    logic                     r_pass;

    assign w_a = i_plane[COEF_W-1:0];
    assign w_b = i_plane[2*COEF_W-1:COEF_W];
    assign w_c = i_plane[3*COEF_W-1:2*COEF_W];
    assign w_d = i_plane[4*COEF_W-1:3*COEF_W];

    assign w_abs_a = w_a[COEF_W-1] ? COEF_W'(-w_a) : COEF_W'(w_a);
    assign w_abs_b = w_b[COEF_W-1] ? COEF_W'(-w_b) : COEF_W'(w_b);
    assign w_abs_c = w_c[COEF_W-1] ? COEF_W'(-w_c) : COEF_W'(w_c);

    assign w_box = (i_item.op == OP_BOX);
    // sphere radius folds into the constant term
    assign w_dr  = DR_W'(w_d) + ((i_item.op == OP_SPHERE)
                   ? $signed({2'b00, i_item.radius}) : DR_W'(0));

    always_ff @(posedge i_clk) begin
        r_ax  <= w_a * i_item.center_x;
        r_by  <= w_b * i_item.center_y;
        r_cz  <= w_c * i_item.center_z;
        r_ex  <= w_box ? EXT_W'(w_abs_a * i_item.half_x) : '0;
        r_ey  <= w_box ? EXT_W'(w_abs_b * i_item.half_y) : '0;
        r_ez  <= w_box ? EXT_W'(w_abs_c * i_item.half_z) : '0;
        r_off <= {w_dr, D_SHIFT'(0)};
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= SUM_W'(r_ax) + SUM_W'(r_by);
        r_s2 <= SUM_W'(r_cz) + SUM_W'(r_off);
        r_s3 <= SUM_W'(r_ex) + SUM_W'(r_ey) + SUM_W'(r_ez);
    end

    assign w_dist = $signed(DIST_W'(r_s1)) + $signed(DIST_W'(r_s2))
                  + $signed(DIST_W'(r_s3));

    always_ff @(posedge i_clk) begin
        r_pass <= (w_dist > $signed(DIST_W'(0)));
    end

    assign o_pass = r_pass;

endmodule

[rtl/core/frustum_cull_test_unit.sv]
// top level of the frustum cull test: input register, plane pipelines, result register
// depends on fcull_pkg, fcull_plane_regs, fcull_plane_unit

// Tests a point, sphere or axis-aligned box against NUM_PLANES clip planes and
// reports whether it survives. A transaction is taken at every clock edge with
// start high (busy is never raised), so the sustained rate is one object per
// cycle. Each object goes through an input register, three stages of the
// per-plane multiply, partial-sum and sign-test pipeline, and the result
// register; o_strobe and o_inside_res come in transaction order and stay for
// one cycle, and the receiver cannot stall them. The user must write plane
// registers through the configuration port only while no transaction is in
// flight; the block does not enforce it. Indexes at or above NUM_PLANES are ignored.

module frustum_cull_test_unit
    import fcull_pkg::*;
#(
    parameter int NUM_PLANES = NUM_PLANES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_op,
    input  logic [COORD_W-1:0]   i_center_x,
    input  logic [COORD_W-1:0]   i_center_y,
    input  logic [COORD_W-1:0]   i_center_z,
    input  logic [SIZE_W-1:0]    i_half_x,
    input  logic [SIZE_W-1:0]    i_half_y,
    input  logic [SIZE_W-1:0]    i_half_z,
    input  logic [SIZE_W-1:0]    i_radius,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PLANE_W-1:0]   i_cfg_data,
    output logic                 o_strobe,
    output logic                 o_inside_res
);

    logic [PLANE_W-1:0]    w_planes [NUM_PLANES];
    logic [NUM_PLANES-1:0] w_pass;
    logic                  w_accept;

    t_item      r_item;
    logic [3:0] r_vld;
    logic       r_strobe;
    logic       r_inside;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    fcull_plane_regs #(
        .NUM_PLANES (NUM_PLANES)
    ) u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_planes   (w_planes)
    );

    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_plane
        fcull_plane_unit u_plane (
            .i_clk   (i_clk),
            .i_plane (w_planes[g]),
            .i_item  (r_item),
            .o_pass  (w_pass[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.op       <= i_op;
            r_item.center_x <= i_center_x;
            r_item.center_y <= i_center_y;
            r_item.center_z <= i_center_z;
            r_item.half_x   <= i_half_x;
            r_item.half_y   <= i_half_y;
            r_item.half_z   <= i_half_z;
            r_item.radius   <= i_radius;
        end
    end

    // valid bits alongside the plane pipelines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_vld    <= {r_vld[2:0], w_accept};
            r_strobe <= r_vld[3];
        end
    end

    always_ff @(posedge i_clk) begin
        r_inside <= &w_pass;
    end

    assign o_strobe     = r_strobe;
    assign o_inside_res = r_inside;

endmodule

[rtl/core/fcull_checker.sv]
// port-level checks on the frustum cull test top level, with its bind
// depends on fcull_pkg and frustum_cull_test_unit

module fcull_checker
    import fcull_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised by a pipeline that never stalls");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_strobe)
        else $error("accepted transaction gave no result after four cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 5))
        else $error("result strobe without a matching accepted transaction");

    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe straight after reset");

endmodule

bind frustum_cull_test_unit fcull_checker u_fcull_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe)
);

[tb/frustum_cull_test_unit_tb.sv]
// self-checking testbench for frustum_cull_test_unit: directed and random objects
// against several plane settings, results checked by a scoreboard class
// depends on fcull_pkg and frustum_cull_test_unit
`timescale 1ns / 100ps

module frustum_cull_test_unit_tb;
    import fcull_pkg::*;

    localparam logic [1:0] OP_SEL3     = 2'd3;  // reserved selector, behaves as a point
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         LATENCY     = 4;
    localparam int         NUM_PHASES  = 12;
    localparam int         PHASE_ITEMS = 58;
    localparam logic signed [COEF_W-1:0] ONE_Q14 = 16'sd16384;

    class cull_checker;
        logic [PLANE_W-1:0] plane_reg[PLANE_SLOTS];
        bit                 inside_due[$];
        int                 n_mismatch;

        function new();
            foreach (plane_reg[p]) plane_reg[p] = '0;
            n_mismatch = 0;
        endfunction

        function void set_plane(logic [CFG_IDX_W-1:0] idx, logic [PLANE_W-1:0] word);
            if (idx < PLANE_SLOTS) plane_reg[idx] = word;
        endfunction

        function longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function bit predict_inside(t_item obj);
            longint a, b, c, d, plane_dist;
            bit     survives;
            survives = 1'b1;
            for (int p = 0; p < NUM_PLANES_DEF; p++) begin
                a = $signed(plane_reg[p][COEF_W-1:0]);
                b = $signed(plane_reg[p][2*COEF_W-1:COEF_W]);
                c = $signed(plane_reg[p][3*COEF_W-1:2*COEF_W]);
                d = $signed(plane_reg[p][4*COEF_W-1:3*COEF_W]);
                plane_dist = a * obj.center_x + b * obj.center_y + c * obj.center_z
                           + (d <<< D_SHIFT);
                if (obj.op == OP_SPHERE)
                    plane_dist = plane_dist + (longint'(obj.radius) <<< D_SHIFT);
                else if (obj.op == OP_BOX)
                    plane_dist = plane_dist + mag(a) * longint'(obj.half_x)
                                            + mag(b) * longint'(obj.half_y)
                                            + mag(c) * longint'(obj.half_z);
                if (plane_dist <= 0) survives = 1'b0;
            end
            return survives;
        endfunction

        function void note_object(t_item obj);
            inside_due.push_back(predict_inside(obj));
        endfunction

        function int pending();
            return inside_due.size();
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $time, what);
            n_mismatch++;
        endtask

        task check_inside(logic got);
            bit want;
            if (inside_due.size() == 0) begin
                report_mismatch("result strobe with no transaction outstanding");
            end else begin
                want = inside_due.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("inside_res got %b expected %b", got, want));
            end
        endtask
    endclass

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    logic                 busy;
    logic [1:0]           i_op       = '0;
    logic [COORD_W-1:0]   i_center_x = '0;
    logic [COORD_W-1:0]   i_center_y = '0;
    logic [COORD_W-1:0]   i_center_z = '0;
    logic [SIZE_W-1:0]    i_half_x   = '0;
    logic [SIZE_W-1:0]    i_half_y   = '0;
    logic [SIZE_W-1:0]    i_half_z   = '0;
    logic [SIZE_W-1:0]    i_radius   = '0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [PLANE_W-1:0]   i_cfg_data = '0;
    logic                 o_strobe;
    logic                 o_inside_res;

    cull_checker chk = new();
    int          cycle_count = 0;
    int          frustum_span = 32767;

    frustum_cull_test_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_center_z   (i_center_z),
        .i_half_x     (i_half_x),
        .i_half_y     (i_half_y),
        .i_half_z     (i_half_z),
        .i_radius     (i_radius),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_inside_res (o_inside_res)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // monitor: register writes, accepted transactions and results
    always @(posedge i_clk) begin
        t_item obj;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end else if (i_rst_n) begin
            if (i_cfg_we) chk.set_plane(i_cfg_idx, i_cfg_data);
            if (o_strobe === 1'b1) chk.check_inside(o_inside_res);
            if (start && !busy) begin
                obj = '{op: i_op, center_x: i_center_x, center_y: i_center_y,
                        center_z: i_center_z, half_x: i_half_x, half_y: i_half_y,
                        half_z: i_half_z, radius: i_radius};
                chk.note_object(obj);
            end
        end
    end

    function automatic logic [PLANE_W-1:0] pack_plane(int a, int b, int c, int d);
        logic [COEF_W-1:0] fa, fb, fc, fd;
        fa = a[COEF_W-1:0];
        fb = b[COEF_W-1:0];
        fc = c[COEF_W-1:0];
        fd = d[COEF_W-1:0];
        return {fd, fc, fb, fa};
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord(int span);
        int lim, v;
        logic [31:0] bits;
        bits = $urandom;
        if ($urandom_range(0, 9) < 3) return bits[COORD_W-1:0];
        lim = (span * 5 / 4 > 32767) ? 32767 : span * 5 / 4;
        v = int'($urandom_range(0, 2 * lim)) - lim;
        return v[COORD_W-1:0];
    endfunction

    function automatic logic [SIZE_W-1:0] rand_size(int span);
        int          v;
        logic [31:0] bits;
        bits = $urandom;
        if ($urandom_range(0, 4) == 0) return bits[SIZE_W-1:0];
        v = $urandom_range(0, span / 2);
        return v[SIZE_W-1:0];
    endfunction

    function automatic t_item rand_object(int span);
        t_item obj;
        int    pick;
        pick = $urandom_range(0, 9);
        obj.op = (pick < 3) ? OP_POINT : (pick < 6) ? OP_SPHERE : (pick < 9) ? OP_BOX : OP_SEL3;
        obj.center_x = rand_coord(span);
        obj.center_y = rand_coord(span);
        obj.center_z = rand_coord(span);
        obj.half_x   = rand_size(span);
        obj.half_y   = rand_size(span);
        obj.half_z   = rand_size(span);
        obj.radius   = rand_size(span);
        return obj;
    endfunction

    function automatic t_item make_object(logic [1:0] op, int x, int y, int z,
                                          int hx, int hy, int hz, int rad);
        t_item obj;
        obj.op       = op;
        obj.center_x = x[COORD_W-1:0];
        obj.center_y = y[COORD_W-1:0];
        obj.center_z = z[COORD_W-1:0];
        obj.half_x   = hx[SIZE_W-1:0];
        obj.half_y   = hy[SIZE_W-1:0];
        obj.half_z   = hz[SIZE_W-1:0];
        obj.radius   = rad[SIZE_W-1:0];
        return obj;
    endfunction

    task automatic send_object(t_item obj);
        @(negedge i_clk);
        start      <= 1'b1;
        i_op       <= obj.op;
        i_center_x <= obj.center_x;
        i_center_y <= obj.center_y;
        i_center_z <= obj.center_z;
        i_half_x   <= obj.half_x;
        i_half_y   <= obj.half_y;
        i_half_z   <= obj.half_z;
        i_radius   <= obj.radius;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        repeat (n) @(negedge i_clk) start <= 1'b0;
    endtask

    task automatic wait_results_idle();
        @(negedge i_clk) start <= 1'b0;
        while (chk.pending() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(int idx, logic [PLANE_W-1:0] word);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx[CFG_IDX_W-1:0];
        i_cfg_data <= word;
        @(negedge i_clk) i_cfg_we <= 1'b0;
    endtask

    // cube of half size span, order -A,+A,-B,+B,-C,+C; tilt and one_wild vary it
    task automatic load_cube(int span, int tilt_max, bit one_wild);
        int coef[3];
        int wild;
        wild = one_wild ? $urandom_range(0, PLANE_SLOTS - 1) : PLANE_SLOTS;
        for (int p = 0; p < PLANE_SLOTS; p++) begin
            foreach (coef[k]) coef[k] = int'($urandom_range(0, 2 * tilt_max)) - tilt_max;
            coef[p / 2] = (p % 2 == 0) ? -ONE_Q14 : ONE_Q14;
            if (p == wild)
                write_reg(p, {$urandom, $urandom});
            else
                write_reg(p, pack_plane(coef[0], coef[1], coef[2], span));
        end
        frustum_span = span;
    endtask

    function automatic int extreme_coef();
        case ($urandom_range(0, 4))
            0:       return 32767;
            1:       return -32768;
            2:       return 0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    task automatic load_extremes();
        for (int p = 0; p < PLANE_SLOTS; p++)
            write_reg(p, pack_plane(extreme_coef(), extreme_coef(), extreme_coef(),
                                    extreme_coef()));
        frustum_span = 32767;
    endtask

    initial begin
        int    pct, burst, kind;
        t_item obj;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // planes still zero after reset
        send_object(make_object(OP_POINT, 0, 0, 0, 0, 0, 0, 0));
        send_object(make_object(OP_SEL3, 5, -5, 7, 0, 0, 0, 9));
        send_object(make_object(OP_BOX, 0, 0, 0, 0, 0, 0, 0));
        send_object(make_object(OP_BOX, 32767, -32768, 1, 32767, 32767, 32767, 0));
        send_object(make_object(OP_SPHERE, 0, 0, 0, 0, 0, 0, 0));
        send_object(make_object(OP_SPHERE, -32768, 32767, 0, 0, 0, 0, 1));
        send_object(make_object(OP_SPHERE, 100, 100, 100, 0, 0, 0, 32767));
        wait_results_idle();

        // cube of half size 1600, writes to unused indexes must be dropped
        load_cube(1600, 0, 1'b0);
        write_reg(PLANE_SLOTS, '1);
        write_reg(PLANE_SLOTS + 1, '1);
        send_object(make_object(OP_POINT, 0, 0, 0, 0, 0, 0, 0));
        send_object(make_object(OP_POINT, 1600, 0, 0, 0, 0, 0, 0));
        send_object(make_object(OP_POINT, 1599, 0, 0, 0, 0, 0, 0));
        send_object(make_object(OP_POINT, 0, -1600, 0, 0, 0, 0, 0));
        send_object(make_object(OP_SEL3, 1599, 0, 0, 0, 0, 0, 50));
        send_object(make_object(OP_SEL3, 0, 0, 1600, 0, 0, 0, 50));
        send_object(make_object(OP_SPHERE, 1616, 0, 0, 0, 0, 0, 16));
        send_object(make_object(OP_SPHERE, 1615, 0, 0, 0, 0, 0, 16));
        send_object(make_object(OP_BOX, 1700, 0, 0, 100, 0, 0, 0));
        send_object(make_object(OP_BOX, 1700, 0, 0, 101, 0, 0, 0));
        send_object(make_object(OP_BOX, 32767, -32768, 0, 32767, 32767, 0, 0));
        send_object(make_object(OP_POINT, 32767, -32768, 0, 32767, 32767, 32767, 32767));
        send_object(make_object(OP_SPHERE, -32768, 32767, -32768, 0, 0, 0, 32767));
        wait_results_idle();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            kind = phase % 4;
            case (kind)
                0:       load_cube($urandom_range(16, 4000), $urandom_range(0, 256), 1'b0);
                1:       load_cube($urandom_range(4000, 32767), 2048, 1'b0);
                2:       load_extremes();
                default: load_cube($urandom_range(16, 32767), 512, 1'b1);
            endcase
            if ($urandom_range(0, 1)) write_reg($urandom_range(PLANE_SLOTS, 7),
                                                {$urandom, $urandom});
            pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 53 : 29;
            burst = 0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                obj = rand_object(frustum_span);
                send_object(obj);
                if (k == PHASE_ITEMS / 2 && phase % 3 == 1) wait_results_idle();
                if (burst > 0)
                    burst--;
                else if ($urandom_range(0, 19) == 0)
                    burst = $urandom_range(8, 20);
                else if ($urandom_range(0, 99) < pct)
                    idle_cycles($urandom_range(1, 3));
            end
            wait_results_idle();
        end

        repeat (LATENCY + 4) @(posedge i_clk);
        if (chk.pending() != 0) chk.report_mismatch("results missing at end of run");
        if (chk.n_mismatch == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
